// ----- rtl/core/sorted_table_insert_delete_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted table assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_DELETE_DEFINES_SVH
`define SORTED_TABLE_INSERT_DELETE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define STID_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define STID_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/core/stid_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted table package
// Capacity, derived widths, command and status codes and the control states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stid_pkg;

  localparam int CAPACITY    = 64;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_LAST,
    S_DEL_SCAN,
    S_DEL_SHIFT,
    S_DONE
  } state_e;

endpackage

// ----- rtl/core/stid_ram.sv -----
// ----------------------------------------------------------------------------
// Sorted table RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- rtl/core/sorted_table_insert_delete.sv -----
// ----------------------------------------------------------------------------
// Sorted table with insert, delete and clear
// Keeps up to CAPACITY signed values in ascending order in one RAM.
// ----------------------------------------------------------------------------
//   Channel  Signals                                  Direction
//   in       in_valid_i, in_ready_o, command_i, value_i   request in
//   out      out_valid_o, out_ready_i, status_o, entry_count_o  result out
//
// Clear, an insert into a full or empty table, a delete from an empty table
// and an unused command skip the scan. Insert walks down from the top
// entry, moving each larger entry up by one; delete walks up to the match
// and then moves the tail down. Both visit one entry at a time through the
// single read port of the table RAM. The table contents need no clearing
// after reset. A stalled result holds only the finish of the next item.
`timescale 1ns / 1ps

module sorted_table_insert_delete (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic signed [stid_pkg::VALUE_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        status_o,
  output logic [stid_pkg::COUNT_OUT_W-1:0]  entry_count_o
);

  import stid_pkg::*;

  `include "sorted_table_insert_delete_defines.svh"

  state_e                     state_q, state_d;
  logic [IDX_W-1:0]           ptr_q, ptr_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  status_e                    pend_q, pend_d;
  logic signed [VALUE_W-1:0]  val_q;
  logic                       res_valid_q, res_valid_d;
  status_e                    res_status_q;
  logic [CNT_W-1:0]           res_cnt_q;
  logic                       load;
  logic                       accept;

  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [VALUE_W-1:0]         wr_data;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [VALUE_W-1:0]         rd_data;

  logic [CNT_W-1:0]           ptr_inc;
  logic [CNT_W-1:0]           ptr_inc2;
  logic                       rd_lt;
  logic                       rd_gt;

  stid_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign accept   = in_valid_i && in_ready_o;
  assign ptr_inc  = CNT_W'(ptr_q) + CNT_W'(1);
  assign ptr_inc2 = CNT_W'(ptr_q) + CNT_W'(2);
  assign rd_lt    = $signed(rd_data) < val_q;
  assign rd_gt    = $signed(rd_data) > val_q;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = res_valid_q;
  assign status_o      = res_status_q;
  assign entry_count_o = COUNT_OUT_W'(res_cnt_q);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    wr_en       = 1'b0;
    wr_addr     = ptr_q;
    wr_data     = rd_data;
    rd_en       = 1'b0;
    rd_addr     = ptr_q;
    load        = 1'b0;
    res_valid_d = res_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_INSERT: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                pend_d  = ST_FULL;
                state_d = S_DONE;
              end else if (cnt_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = value_i;
                cnt_d   = cnt_q + CNT_W'(1);
                pend_d  = ST_INSERTED;
                state_d = S_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(cnt_q - CNT_W'(1));
                ptr_d   = IDX_W'(cnt_q - CNT_W'(1));
                state_d = S_INS_SCAN;
              end
            end
            CMD_DELETE: begin
              if (cnt_q == '0) begin
                pend_d  = ST_NOT_FOUND;
                state_d = S_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                ptr_d   = '0;
                state_d = S_DEL_SCAN;
              end
            end
            CMD_CLEAR: begin
              cnt_d   = '0;
              pend_d  = ST_CLEARED;
              state_d = S_DONE;
            end
            default: begin
              pend_d  = ST_NOT_FOUND;
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Read data holds entry ptr_q; larger entries move up one place.
      S_INS_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(ptr_inc);
        if (rd_gt) begin
          wr_data = rd_data;
          if (ptr_q == '0) begin
            state_d = S_INS_LAST;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_q - IDX_W'(1);
            ptr_d   = ptr_q - IDX_W'(1);
          end
        end else begin
          wr_data = val_q;
          cnt_d   = cnt_q + CNT_W'(1);
          pend_d  = ST_INSERTED;
          state_d = S_DONE;
        end
      end

      S_INS_LAST: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = val_q;
        cnt_d   = cnt_q + CNT_W'(1);
        pend_d  = ST_INSERTED;
        state_d = S_DONE;
      end

      // The read of the next entry is issued each cycle, so a match can
      // move straight into the shift.
      S_DEL_SCAN: begin
        if (rd_gt) begin
          pend_d  = ST_NOT_FOUND;
          state_d = S_DONE;
        end else if (ptr_inc == cnt_q) begin
          if (rd_lt) begin
            pend_d = ST_NOT_FOUND;
          end else begin
            cnt_d  = cnt_q - CNT_W'(1);
            pend_d = ST_DELETED;
          end
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(ptr_inc);
          if (rd_lt) begin
            ptr_d = IDX_W'(ptr_inc);
          end else begin
            state_d = S_DEL_SHIFT;
          end
        end
      end

      // Read data holds entry ptr_q + 1, which moves down into ptr_q.
      S_DEL_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        wr_data = rd_data;
        ptr_d   = IDX_W'(ptr_inc);
        if (ptr_inc2 == cnt_q) begin
          cnt_d   = cnt_q - CNT_W'(1);
          pend_d  = ST_DELETED;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(ptr_inc2);
        end
      end

      S_DONE: begin
        if (!res_valid_q || out_ready_i) begin
          load        = 1'b1;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= ST_NOT_FOUND;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= value_i;
    end
    if (load) begin
      res_status_q <= pend_q;
      res_cnt_q    <= cnt_q;
    end
  end

  `STID_ASSERT(a_count_bound, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `STID_ASSERT(a_accept_leaves_idle, accept |=> state_q != S_IDLE, "accepted item did no work")
  `STID_ASSERT(a_result_from_done, $rose(out_valid_o) |-> $past(state_q == S_DONE),
               "result appeared outside the finish step")
  `STID_ASSERT(a_full_at_capacity,
               (out_valid_o && res_status_q == ST_FULL) |-> res_cnt_q == CNT_W'(CAPACITY),
               "full status with room left")
  `STID_ASSERT_NEVER(a_write_in_range, wr_en && (CNT_W'(wr_addr) > cnt_q),
                     "table write beyond the stored entries")

endmodule
